[hdl/frp_pkg.sv]
`default_nettype none

package frp_pkg;

  // Result kinds carried on out_tuser
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_SEQ   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [31:0] len;
  } result_t;

  function automatic logic is_skip_space(input logic [7:0] c);
    is_skip_space = (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
                    (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    is_lower = (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = ((c >= 8'h41) && (c <= 8'h5A)) || is_lower(c) ||
               ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

`default_nettype wire

[hdl/fasta_record_parser.sv]
// FASTA record parser: one text byte per input item.
// Input channel: in_tdata carries a text byte, in_tlast marks end of stream
// (the byte is then ignored). Output channel: out_tuser gives the kind of
// result (name byte, sequence byte, record end, format error), out_tdata the
// character and, with record end, the saturating sequence length.
// The cfg channel writes the upper-case enable, which upper-cases kept
// sequence letters; write it only while the block is idle. cfg_ready is high.
// Each accepted item is held in an input register, stepped by the parser
// state machine and, when it produces a result, lands in the output
// register; out_tvalid comes from that register. Throughput is one item
// per cycle while the receiver does not stall.
// Items that produce no result are simply dropped after the step.
// When the receiver stalls, the output register holds its item and the
// input register fills; in_tready drops only when both are occupied.
// After a format error the parser stays silent until reset.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to seeking a header at line start, clears the count and the upper-case enable.
`default_nettype none

module fasta_record_parser
  import frp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,   // end_of_stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] char_out, [39:8] record_length
  output logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // upcase_en
);

  localparam logic [2:0] MODE_SEEK      = 3'd0;
  localparam logic [2:0] MODE_HDR_SKIP  = 3'd1;
  localparam logic [2:0] MODE_HDR_NAME  = 3'd2;
  localparam logic [2:0] MODE_HDR_REST  = 3'd3;
  localparam logic [2:0] MODE_SEQ_FIRST = 3'd4;
  localparam logic [2:0] MODE_SEQ       = 3'd5;
  localparam logic [2:0] MODE_ERROR     = 3'd6;

  logic        stg_vld_r;
  logic [7:0]  stg_byte_r;
  logic        stg_eos_r;
  logic        out_vld_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_ch_r;
  logic [31:0] out_len_r;
  logic [2:0]  mode_r, mode_nxt;
  logic        als_r, als_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        upper_r;
  logic        adv;
  logic        step;
  result_t     res;

  // advance the step stage whenever the output register is free or draining
  assign adv       = !out_vld_r || out_tready;
  assign step      = stg_vld_r && adv;
  assign in_tready = !stg_vld_r || adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_len_r, out_ch_r};

  always_comb begin
    mode_nxt = mode_r;
    als_nxt  = als_r;
    cnt_nxt  = cnt_r;
    res.vld  = 1'b0;
    res.kind = KIND_NAME;
    res.ch   = 8'd0;
    res.len  = 32'd0;
    case (mode_r)
      MODE_SEEK: begin
        if (stg_eos_r) begin
          mode_nxt = MODE_ERROR;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
        end else if (als_r && stg_byte_r == CH_GT) begin
          mode_nxt = MODE_HDR_SKIP;
          als_nxt  = 1'b0;
        end else begin
          als_nxt = (stg_byte_r == CH_LF);
        end
      end
      MODE_HDR_SKIP: begin
        if (stg_eos_r || stg_byte_r == CH_LF) begin
          mode_nxt = MODE_ERROR;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
        end else if (!(stg_byte_r == CH_GT || is_skip_space(stg_byte_r))) begin
          mode_nxt = MODE_HDR_NAME;
          res.vld  = 1'b1;
          res.kind = KIND_NAME;
          res.ch   = stg_byte_r;
        end
      end
      MODE_HDR_NAME: begin
        if (stg_eos_r) begin
          mode_nxt = MODE_ERROR;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
        end else if (stg_byte_r == CH_LF) begin
          mode_nxt = MODE_SEQ_FIRST;
          als_nxt  = 1'b1;
        end else if (stg_byte_r == CH_SP || stg_byte_r == CH_TAB ||
                     stg_byte_r == CH_CR) begin
          mode_nxt = MODE_HDR_REST;
        end else begin
          res.vld  = 1'b1;
          res.kind = KIND_NAME;
          res.ch   = stg_byte_r;
        end
      end
      MODE_HDR_REST: begin
        if (stg_eos_r) begin
          mode_nxt = MODE_ERROR;
          res.vld  = 1'b1;
          res.kind = KIND_ERROR;
        end else if (stg_byte_r == CH_LF) begin
          mode_nxt = MODE_SEQ_FIRST;
          als_nxt  = 1'b1;
        end
      end
      MODE_SEQ_FIRST, MODE_SEQ: begin
        if (stg_eos_r) begin
          res.vld = 1'b1;
          if (mode_r == MODE_SEQ_FIRST) begin
            // header line with nothing after it
            mode_nxt = MODE_ERROR;
            res.kind = KIND_ERROR;
          end else begin
            mode_nxt = MODE_SEEK;
            als_nxt  = 1'b1;
            cnt_nxt  = 32'd0;
            res.kind = KIND_END;
            res.len  = cnt_r;
          end
        end else if (als_r && stg_byte_r == CH_GT) begin
          // next header closes this record
          mode_nxt = MODE_HDR_SKIP;
          als_nxt  = 1'b0;
          cnt_nxt  = 32'd0;
          res.vld  = 1'b1;
          res.kind = KIND_END;
          res.len  = cnt_r;
        end else begin
          mode_nxt = MODE_SEQ;
          als_nxt  = (stg_byte_r == CH_LF);
          if (is_alnum(stg_byte_r)) begin
            res.vld  = 1'b1;
            res.kind = KIND_SEQ;
            res.ch   = (upper_r && is_lower(stg_byte_r)) ?
                       (stg_byte_r - 8'd32) : stg_byte_r;
            if (cnt_r != LEN_MAX) begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
        end
      end
      default: begin
        // error or unused code: stay silent
        mode_nxt = MODE_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      mode_r    <= MODE_SEEK;
      als_r     <= 1'b1;
      cnt_r     <= 32'd0;
      upper_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        upper_r <= cfg_data;
      end
      if (in_tready) begin
        stg_vld_r <= in_tvalid;
      end
      if (step) begin
        mode_r <= mode_nxt;
        als_r  <= als_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (adv) begin
        out_vld_r <= step && res.vld;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_byte_r <= in_tdata;
      stg_eos_r  <= in_tlast;
    end
    if (step && res.vld) begin
      out_kind_r <= res.kind;
      out_ch_r   <= res.ch;
      out_len_r  <= res.len;
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ERROR |=> mode_r == MODE_ERROR)
    else $error("parser left error mode");

  a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.vld && res.kind == KIND_END |=> cnt_r == 32'd0)
    else $error("count not cleared at record end");

  a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_ERROR |=> !out_tvalid)
    else $error("result after format error");

  a_end_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_ERROR)
      |-> out_tdata[7:0] == 8'd0)
    else $error("character set on record end or error");
`endif

endmodule

`default_nettype wire
